// ----- sv/hpmc_pkg.sv -----
package hpmc_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 5;
    localparam int MODE_W      = 2;
    localparam int HEIGHT_W    = 5;

    typedef logic [MODE_W-1:0]      mode_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam mode_t MODE_COPY  = 2'd0;
    localparam mode_t MODE_HORIZ = 2'd1;
    localparam mode_t MODE_VERT  = 2'd2;
    localparam mode_t MODE_DIAG  = 2'd3;

    localparam cfg_index_t REG_WIDTH_SEL = 3'd0;
    localparam cfg_index_t REG_HEIGHT    = 3'd1;
    localparam cfg_index_t REG_FWD_MODE  = 3'd2;
    localparam cfg_index_t REG_BWD_MODE  = 3'd3;
    localparam cfg_index_t REG_BIDIR     = 3'd4;

endpackage

// ----- sv/half_pel_motion_comp_predictor.sv -----
// Result beats are registered in the output buffer, which drives out_valid.
// Throughput: one window pixel per cycle while in_stall is low; the line store is a row of
// cells read and written in the same cycle, and a two-beat output buffer absorbs output stalls.
// Reset: position, left and above-left pixels and the output buffer clear; configuration
// returns to 16 by 16, copy mode, forward only. Line store contents are undefined until written.
module half_pel_motion_comp_predictor #(
    parameter int MAX_WIDTH  = 16,
    parameter int MAX_HEIGHT = 16,
    parameter int PIXEL_BITS = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [hpmc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [hpmc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [PIXEL_BITS-1:0]          fwd_pixel,
    input  logic [PIXEL_BITS-1:0]          bwd_pixel,
    input  logic                           window_start,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [PIXEL_BITS-1:0]          pred_pixel,
    output logic                           block_last
);

    localparam int COL_W    = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W    = $clog2(MAX_HEIGHT + 1);
    localparam int CMP_W    = (ROW_W > hpmc_pkg::HEIGHT_W) ? ROW_W : hpmc_pkg::HEIGHT_W;
    localparam int WIDE_W   = (MAX_WIDTH < 16) ? MAX_WIDTH : 16;
    localparam int NARROW_W = 8;
    localparam int CELLS    = MAX_WIDTH + 1;

    logic                         width_sel_reg;
    logic [hpmc_pkg::HEIGHT_W-1:0] height_reg;
    hpmc_pkg::mode_t              fwd_mode_reg;
    hpmc_pkg::mode_t              bwd_mode_reg;
    logic                         bidir_reg;

    logic [COL_W-1:0]      col_reg;
    logic [COL_W-1:0]      col_next;
    logic [ROW_W-1:0]      row_reg;
    logic [ROW_W-1:0]      row_next;
    logic [PIXEL_BITS-1:0] fwd_left_reg;
    logic [PIXEL_BITS-1:0] bwd_left_reg;
    logic [PIXEL_BITS-1:0] fwd_above_left_reg;
    logic [PIXEL_BITS-1:0] bwd_above_left_reg;

    logic                  in_accept;
    logic                  buf_full;
    logic [COL_W-1:0]      col;
    logic [ROW_W-1:0]      row;
    logic [COL_W-1:0]      width;
    logic [CMP_W-1:0]      height_ext;
    logic [CMP_W-1:0]      height_clamp;
    logic [ROW_W-1:0]      height;
    logic                  produce;
    logic                  last;
    logic [PIXEL_BITS-1:0] fwd_above;
    logic [PIXEL_BITS-1:0] bwd_above;
    logic [PIXEL_BITS-1:0] fwd_pred;
    logic [PIXEL_BITS-1:0] bwd_pred;
    logic [PIXEL_BITS:0]   bidir_sum;
    logic [PIXEL_BITS-1:0] pred;
    logic [PIXEL_BITS:0]   out_data;

    logic [PIXEL_BITS-1:0] fwd_chain [CELLS+1];
    logic [PIXEL_BITS-1:0] bwd_chain [CELLS+1];

    assign cfg_ready = 1'b1;
    assign in_stall  = buf_full;
    assign in_accept = in_valid && !buf_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_sel_reg <= 1'b1;
            height_reg    <= hpmc_pkg::HEIGHT_W'(16);
            fwd_mode_reg  <= hpmc_pkg::MODE_COPY;
            bwd_mode_reg  <= hpmc_pkg::MODE_COPY;
            bidir_reg     <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                hpmc_pkg::REG_WIDTH_SEL: width_sel_reg <= cfg_data[0];
                hpmc_pkg::REG_HEIGHT:    height_reg    <= cfg_data;
                hpmc_pkg::REG_FWD_MODE:  fwd_mode_reg  <= cfg_data[hpmc_pkg::MODE_W-1:0];
                hpmc_pkg::REG_BWD_MODE:  bwd_mode_reg  <= cfg_data[hpmc_pkg::MODE_W-1:0];
                hpmc_pkg::REG_BIDIR:     bidir_reg     <= cfg_data[0];
                default:                 ;
            endcase
        end
    end

    assign width        = width_sel_reg ? COL_W'(WIDE_W) : COL_W'(NARROW_W);
    assign height_ext   = CMP_W'(height_reg);
    assign height_clamp = (height_ext == '0) ? CMP_W'(1)
                        : ((height_ext > CMP_W'(MAX_HEIGHT)) ? CMP_W'(MAX_HEIGHT) : height_ext);
    assign height       = height_clamp[ROW_W-1:0];

    assign col = window_start ? '0 : col_reg;
    assign row = window_start ? '0 : row_reg;

    assign fwd_chain[0] = '0;
    assign bwd_chain[0] = '0;

    for (genvar k = 0; k < CELLS; k++)
    begin : g_line
        hpmc_line_cell #(
            .INDEX      (k),
            .COL_W      (COL_W),
            .PIXEL_BITS (PIXEL_BITS)
        ) u_cell (
            .clk        (clk),
            .wr_en      (in_accept),
            .col        (col),
            .fwd_wr     (fwd_pixel),
            .bwd_wr     (bwd_pixel),
            .fwd_rd_in  (fwd_chain[k]),
            .bwd_rd_in  (bwd_chain[k]),
            .fwd_rd_out (fwd_chain[k+1]),
            .bwd_rd_out (bwd_chain[k+1])
        );
    end

    assign fwd_above = fwd_chain[CELLS];
    assign bwd_above = bwd_chain[CELLS];

    hpmc_pel_unit #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_fwd_pel (
        .mode (fwd_mode_reg),
        .a    (fwd_above_left_reg),
        .b    (fwd_above),
        .c    (fwd_left_reg),
        .d    (fwd_pixel),
        .pred (fwd_pred)
    );

    hpmc_pel_unit #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_bwd_pel (
        .mode (bwd_mode_reg),
        .a    (bwd_above_left_reg),
        .b    (bwd_above),
        .c    (bwd_left_reg),
        .d    (bwd_pixel),
        .pred (bwd_pred)
    );

    assign bidir_sum = {1'b0, fwd_pred} + {1'b0, bwd_pred} + (PIXEL_BITS+1)'(1);
    assign pred      = bidir_reg ? bidir_sum[PIXEL_BITS:1] : fwd_pred;

    assign produce = (row != '0) && (col != '0) && (row <= height) && (col <= width);
    assign last    = (row == height) && (col == width);

    always_comb
    begin
        if (col >= width)
        begin
            col_next = '0;
            row_next = (row >= height) ? '0 : row + ROW_W'(1);
        end
        else
        begin
            col_next = col + COL_W'(1);
            row_next = (row > height) ? '0 : row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg            <= '0;
            row_reg            <= '0;
            fwd_left_reg       <= '0;
            bwd_left_reg       <= '0;
            fwd_above_left_reg <= '0;
            bwd_above_left_reg <= '0;
        end
        else if (in_accept)
        begin
            col_reg            <= col_next;
            row_reg            <= row_next;
            fwd_left_reg       <= fwd_pixel;
            bwd_left_reg       <= bwd_pixel;
            fwd_above_left_reg <= fwd_above;
            bwd_above_left_reg <= bwd_above;
        end
    end

    hpmc_out_buf #(
        .WIDTH (PIXEL_BITS + 1)
    ) u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_accept && produce),
        .push_data ({last, pred}),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign pred_pixel = out_data[PIXEL_BITS-1:0];
    assign block_last = out_data[PIXEL_BITS];

endmodule

// ----- sv/hpmc_line_cell.sv -----
module hpmc_line_cell #(
    parameter int INDEX      = 0,
    parameter int COL_W      = 5,
    parameter int PIXEL_BITS = 8
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [COL_W-1:0]      col,
    input  logic [PIXEL_BITS-1:0] fwd_wr,
    input  logic [PIXEL_BITS-1:0] bwd_wr,
    input  logic [PIXEL_BITS-1:0] fwd_rd_in,
    input  logic [PIXEL_BITS-1:0] bwd_rd_in,
    output logic [PIXEL_BITS-1:0] fwd_rd_out,
    output logic [PIXEL_BITS-1:0] bwd_rd_out
);

    logic [PIXEL_BITS-1:0] fwd_reg;
    logic [PIXEL_BITS-1:0] bwd_reg;
    logic                  hit;

    assign hit = (col == COL_W'(INDEX));

    always_ff @(posedge clk)
    begin
        if (wr_en && hit)
        begin
            fwd_reg <= fwd_wr;
            bwd_reg <= bwd_wr;
        end
    end

    // pass the neighbour's read data on, merged with this entry when addressed
    assign fwd_rd_out = fwd_rd_in | (hit ? fwd_reg : '0);
    assign bwd_rd_out = bwd_rd_in | (hit ? bwd_reg : '0);

endmodule

// ----- sv/hpmc_pel_unit.sv -----
module hpmc_pel_unit #(
    parameter int PIXEL_BITS = 8
) (
    input  hpmc_pkg::mode_t       mode,
    input  logic [PIXEL_BITS-1:0] a,
    input  logic [PIXEL_BITS-1:0] b,
    input  logic [PIXEL_BITS-1:0] c,
    input  logic [PIXEL_BITS-1:0] d,
    output logic [PIXEL_BITS-1:0] pred
);

    logic [PIXEL_BITS:0]   sum_ab;
    logic [PIXEL_BITS:0]   sum_ac;
    logic [PIXEL_BITS+1:0] sum_abcd;

    assign sum_ab   = {1'b0, a} + {1'b0, b} + (PIXEL_BITS+1)'(1);
    assign sum_ac   = {1'b0, a} + {1'b0, c} + (PIXEL_BITS+1)'(1);
    assign sum_abcd = {2'b00, a} + {2'b00, b} + {2'b00, c} + {2'b00, d}
                    + (PIXEL_BITS+2)'(2);

    always_comb
    begin
        case (mode)
            hpmc_pkg::MODE_COPY:  pred = a;
            hpmc_pkg::MODE_HORIZ: pred = sum_ab[PIXEL_BITS:1];
            hpmc_pkg::MODE_VERT:  pred = sum_ac[PIXEL_BITS:1];
            default:              pred = sum_abcd[PIXEL_BITS+1:2];
        endcase
    end

endmodule

// ----- sv/hpmc_out_buf.sv -----
module hpmc_out_buf #(
    parameter int WIDTH = 9
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [WIDTH-1:0] out_data
);

    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic [WIDTH-1:0] head_reg;
    logic [WIDTH-1:0] head_next;
    logic [WIDTH-1:0] tail_reg;
    logic [WIDTH-1:0] tail_next;
    logic             pop;

    assign out_valid = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);
    assign out_data  = head_reg;
    assign pop       = out_valid && !out_stall;

    always_comb
    begin
        count_next = count_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        if (pop && !push)
        begin
            head_next  = tail_reg;
            count_next = count_reg - 2'd1;
        end
        else if (push && !pop)
        begin
            if (count_reg == 2'd0)
                head_next = push_data;
            else
                tail_next = push_data;
            count_next = count_reg + 2'd1;
        end
        else if (push && pop)
        begin
            if (count_reg == 2'd1)
                head_next = push_data;
            else
            begin
                head_next = tail_reg;
                tail_next = push_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule
